// File: sv/mbe_pkg.sv
package mbe_pkg;

  // fixed field widths
  localparam int COORD_W     = 32;
  localparam int FRAC_W      = 26;
  localparam int IDX_W       = 12;
  localparam int DIM_REG_W   = 13;
  localparam int COUNT_W     = 16;
  localparam int ADDR_W      = 24;
  localparam int DEF_MAX_DIM = 4096;

  // datapath widths
  localparam int SPAN_W = COORD_W + 1;
  localparam int OPND_W = SPAN_W;
  localparam int PROD_W = 2 * COORD_W;
  localparam int MAG_W  = COORD_W + IDX_W;
  localparam int SQ_W   = PROD_W - FRAC_W;
  localparam int WIDE_W = MAG_W + 2;

  // stream and register port widths
  localparam int S_TDATA_W  = 2 * IDX_W;
  localparam int M_TDATA_W  = COUNT_W + ADDR_W;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  // register map
  localparam logic [REG_IDX_W-1:0] REG_X_MIN           = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_X_MAX           = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_Y_MIN           = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_Y_MAX           = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ITERATION_LIMIT = 3'd6;

  // register reset values
  localparam logic [COORD_W-1:0]   RST_X_MIN  = 32'hF800_0000;
  localparam logic [COORD_W-1:0]   RST_X_MAX  = 32'h0400_0000;
  localparam logic [COORD_W-1:0]   RST_Y_MIN  = 32'hFC00_0000;
  localparam logic [COORD_W-1:0]   RST_Y_MAX  = 32'h0400_0000;
  localparam logic [DIM_REG_W-1:0] RST_DIM    = 13'd1024;
  localparam logic [COUNT_W-1:0]   RST_LIMIT  = 16'd256;

  // saturation bounds and escape radius squared (4.0)
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [WIDE_W-1:0]  WIDE_MAX  =
    {{(WIDE_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0]  WIDE_MIN  =
    {{(WIDE_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
  localparam logic signed [SQ_W:0] ESCAPE_LIMIT = (SQ_W+1)'(64'd4 << FRAC_W);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_DIV,
    ST_MAP_WAIT,
    ST_ADDR_MUL,
    ST_ADDR_WR,
    ST_IT_AA,
    ST_IT_BB,
    ST_IT_AB,
    ST_IT_UPD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_min;
    logic signed [COORD_W-1:0] x_max;
    logic signed [COORD_W-1:0] y_min;
    logic signed [COORD_W-1:0] y_max;
    logic [DIM_REG_W-1:0]      image_width;
    logic [DIM_REG_W-1:0]      image_height;
    logic [COUNT_W-1:0]        iteration_limit;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // clamp a wide signed value to the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [COORD_W-1:0] r;
    if (v > WIDE_MAX) begin
      r = COORD_MAX;
    end else if (v < WIDE_MIN) begin
      r = COORD_MIN;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: sv/mbe_regs.sv
module mbe_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mbe_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [mbe_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [mbe_pkg::APB_DATA_W-1:0]   prdata,
  output mbe_pkg::cfg_t                    cfg
);
  import mbe_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_min           <= RST_X_MIN;
      cfg.x_max           <= RST_X_MAX;
      cfg.y_min           <= RST_Y_MIN;
      cfg.y_max           <= RST_Y_MAX;
      cfg.image_width     <= RST_DIM;
      cfg.image_height    <= RST_DIM;
      cfg.iteration_limit <= RST_LIMIT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_X_MIN:           cfg.x_min           <= pwdata[COORD_W-1:0];
        REG_X_MAX:           cfg.x_max           <= pwdata[COORD_W-1:0];
        REG_Y_MIN:           cfg.y_min           <= pwdata[COORD_W-1:0];
        REG_Y_MAX:           cfg.y_max           <= pwdata[COORD_W-1:0];
        REG_IMAGE_WIDTH:     cfg.image_width     <= pwdata[DIM_REG_W-1:0];
        REG_IMAGE_HEIGHT:    cfg.image_height    <= pwdata[DIM_REG_W-1:0];
        REG_ITERATION_LIMIT: cfg.iteration_limit <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_X_MIN:           prdata = APB_DATA_W'(cfg.x_min);
      REG_X_MAX:           prdata = APB_DATA_W'(cfg.x_max);
      REG_Y_MIN:           prdata = APB_DATA_W'(cfg.y_min);
      REG_Y_MAX:           prdata = APB_DATA_W'(cfg.y_max);
      REG_IMAGE_WIDTH:     prdata = APB_DATA_W'(cfg.image_width);
      REG_IMAGE_HEIGHT:    prdata = APB_DATA_W'(cfg.image_height);
      REG_ITERATION_LIMIT: prdata = APB_DATA_W'(cfg.iteration_limit);
      default:             prdata = '0;
    endcase
  end

endmodule

// File: sv/mbe_mul.sv
module mbe_mul (
  input  logic                                clk,
  input  logic signed [mbe_pkg::OPND_W-1:0]   op_a,
  input  logic signed [mbe_pkg::OPND_W-1:0]   op_b,
  output logic signed [mbe_pkg::PROD_W-1:0]   prod
);
  import mbe_pkg::*;

  logic signed [2*OPND_W-1:0] full;

  // shared signed multiplier, product registered
  assign full = op_a * op_b;

  always_ff @(posedge clk) begin
    prod <= full[PROD_W-1:0];
  end

endmodule

// File: sv/mbe_div.sv
module mbe_div #(
  parameter int DIM_W = 13
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [mbe_pkg::MAG_W-1:0]       dividend,
  input  logic [DIM_W-1:0]                divisor,
  output mbe_pkg::div_stat_t              stat,
  output logic [mbe_pkg::MAG_W-1:0]       quotient
);
  import mbe_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DIM_W-1:0] rem;
  logic [MAG_W-1:0] quo;
  logic [DIM_W-1:0] dvsr;
  logic [DIM_W:0]   rem_sh;
  logic [DIM_W:0]   rem_diff;
  logic             fits;

  // one restoring step per cycle
  assign rem_sh   = {rem, quo[MAG_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvsr};
  assign fits     = rem_sh >= {1'b0, dvsr};

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(MAG_W);
    end else if (busy) begin
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy && cnt != '0) begin
      rem <= fits ? rem_diff[DIM_W-1:0] : rem_sh[DIM_W-1:0];
      quo <= {quo[MAG_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = busy && (cnt == '0);
  assign quotient  = quo;

endmodule

// File: sv/mandelbrot_escape_time.sv
// Mandelbrot escape-time pixel unit
//
// s_axis carries one pixel request (column, row); m_axis returns the escape
// count and the pixel's linear address. Both are valid/ready streams; the
// APB port sets the viewing window, image size and iteration limit and
// should only be written while no pixel is in flight.
//
// Each axis mapping runs through the 44-step restoring divider; the single
// shared multiplier forms a*a, b*b and a*b in turn for each iteration, and
// the loop ends at the iteration limit or after an escape. One pixel is
// worked on at a time: a new request is taken only once the last pixel's
// result has been loaded into the output register.
//
// Reset returns the sequencer to idle, empties the output register and
// loads the default window. A finished result waits in the output register
// while the next pixel is accepted and worked on; if the receiver still
// stalls when that pixel is done, the unit holds until the register frees.
module mandelbrot_escape_time #(
  parameter int MAX_DIM = mbe_pkg::DEF_MAX_DIM
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // column [11:0], row [23:12]
  input  logic [mbe_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // iteration_count [15:0], pixel_address [39:16]
  output logic [mbe_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mbe_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mbe_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mbe_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import mbe_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  state_t state, state_next;
  cfg_t   cfg;

  logic [IDX_W-1:0]          col_q, row_q;
  logic [DIM_W-1:0]          w_q, h_q, w_eff, h_eff;
  logic                      axis_y;
  logic                      q_neg;
  logic signed [COORD_W-1:0] cx, cy, a, b;
  logic signed [SQ_W-1:0]    a2, b2, sq_cur;
  logic [COUNT_W-1:0]        t;
  logic [ADDR_W-1:0]         addr_q;
  logic [COUNT_W-1:0]        out_count;
  logic [ADDR_W-1:0]         out_addr;
  logic                      out_valid;
  logic                      out_free, out_load, accept;

  logic signed [OPND_W-1:0]  op_a, op_b, span_x, span_y;
  logic signed [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]         prod_neg;

  logic                      div_start;
  logic [MAG_W-1:0]          dividend, quotient;
  div_stat_t                 div_stat;

  logic signed [WIDE_W-1:0]  off_w, lo_w, map_sum;
  logic signed [COORD_W-1:0] map_sat, re_next, im_next;
  logic signed [SQ_W:0]      mag_sum;
  logic                      escaped, at_limit;

  // configuration registers
  mbe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  // shared multiplier
  mbe_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // mapping divider
  mbe_div #(
    .DIM_W (DIM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (axis_y ? h_q : w_q),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // effective image dimensions
  always_comb begin
    if (cfg.image_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(cfg.image_width) > MAX_DIM) begin
      w_eff = DIM_W'(MAX_DIM);
    end else begin
      w_eff = DIM_W'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(cfg.image_height) > MAX_DIM) begin
      h_eff = DIM_W'(MAX_DIM);
    end else begin
      h_eff = DIM_W'(cfg.image_height);
    end
  end

  // axis spans and divider operand
  assign span_x   = SPAN_W'($signed(cfg.x_max)) - SPAN_W'($signed(cfg.x_min));
  assign span_y   = SPAN_W'($signed(cfg.y_max)) - SPAN_W'($signed(cfg.y_min));
  assign prod_neg = -prod;
  assign dividend = prod[PROD_W-1] ? prod_neg[MAG_W-1:0] : prod[MAG_W-1:0];

  // mapped coordinate: lower bound plus signed truncated quotient
  always_comb begin
    off_w   = $signed(WIDE_W'(quotient));
    if (q_neg) begin
      off_w = -off_w;
    end
    lo_w    = axis_y ? WIDE_W'($signed(cfg.y_min)) : WIDE_W'($signed(cfg.x_min));
    map_sum = lo_w + off_w;
    map_sat = sat_coord(map_sum);
  end

  // iteration arithmetic, product scaled back with floor
  assign sq_cur   = prod[PROD_W-1:FRAC_W];
  assign mag_sum  = (SQ_W+1)'(a2) + (SQ_W+1)'(sq_cur);
  assign escaped  = mag_sum > ESCAPE_LIMIT;
  assign at_limit = t >= cfg.iteration_limit;
  assign re_next  = sat_coord(WIDE_W'(a2) - WIDE_W'(b2) + WIDE_W'(cx));
  assign im_next  = sat_coord((WIDE_W'(sq_cur) <<< 1) + WIDE_W'(cy));

  assign out_free = !out_valid || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (s_axis_tvalid) state_next = ST_MAP_MUL;
      ST_MAP_MUL:  state_next = ST_MAP_DIV;
      ST_MAP_DIV:  state_next = ST_MAP_WAIT;
      ST_MAP_WAIT: begin
        if (div_stat.done) begin
          state_next = axis_y ? ST_ADDR_MUL : ST_MAP_MUL;
        end
      end
      ST_ADDR_MUL: state_next = ST_ADDR_WR;
      ST_ADDR_WR:  state_next = ST_IT_AA;
      ST_IT_AA:    state_next = at_limit ? ST_DONE : ST_IT_BB;
      ST_IT_BB:    state_next = ST_IT_AB;
      ST_IT_AB:    state_next = escaped ? ST_DONE : ST_IT_UPD;
      ST_IT_UPD:   state_next = ST_IT_AA;
      ST_DONE:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs and multiplier operand select
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    op_a          = '0;
    op_b          = '0;
    unique case (state)
      ST_IDLE:     s_axis_tready = 1'b1;
      ST_MAP_MUL: begin
        op_a = axis_y ? span_y : span_x;
        op_b = OPND_W'(axis_y ? row_q : col_q);
      end
      ST_MAP_DIV:  div_start = 1'b1;
      ST_ADDR_MUL: begin
        op_a = OPND_W'(row_q);
        op_b = OPND_W'(w_q);
      end
      ST_IT_AA: begin
        op_a = OPND_W'(a);
        op_b = OPND_W'(a);
      end
      ST_IT_BB: begin
        op_a = OPND_W'(b);
        op_b = OPND_W'(b);
      end
      ST_IT_AB: begin
        op_a = OPND_W'(a);
        op_b = OPND_W'(b);
      end
      ST_DONE:     out_load = out_free;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis_y    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        axis_y <= 1'b0;
      end else if (state == ST_MAP_WAIT && div_stat.done) begin
        axis_y <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          col_q <= s_axis_tdata[IDX_W-1:0];
          row_q <= s_axis_tdata[2*IDX_W-1:IDX_W];
          w_q   <= w_eff;
          h_q   <= h_eff;
          a     <= '0;
          b     <= '0;
          t     <= '0;
        end
      end
      ST_MAP_DIV:  q_neg <= prod[PROD_W-1];
      ST_MAP_WAIT: begin
        if (div_stat.done) begin
          if (axis_y) begin
            cy <= map_sat;
          end else begin
            cx <= map_sat;
          end
        end
      end
      ST_ADDR_WR:  addr_q <= prod[ADDR_W-1:0] + ADDR_W'(col_q);
      ST_IT_BB:    a2 <= sq_cur;
      ST_IT_AB:    b2 <= sq_cur;
      ST_IT_UPD: begin
        a <= re_next;
        b <= im_next;
        t <= t + 1'b1;
      end
      ST_DONE: begin
        if (out_load) begin
          out_count <= t;
          out_addr  <= addr_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_addr, out_count};

endmodule

// File: sv/mbe_assert.sv
module mbe_assert (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [mbe_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  input logic                              pready
);

  // output register empties on reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a pixel in work blocks further requests
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while a pixel is in work");

  // no result can appear right after a request is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared without any work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // register port never waits
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind mandelbrot_escape_time mbe_assert u_mbe_assert (.*);
